// ===== hw/rtl/kps_pkg.sv =====
package kps_pkg;

  // Width of the tick counter; limits above its maximum saturate to it.
  localparam int TIMER_WIDTH = 16;
  localparam int LIMIT_WIDTH = 16;
  localparam int CMP_WIDTH = (TIMER_WIDTH > LIMIT_WIDTH) ? TIMER_WIDTH : LIMIT_WIDTH;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  localparam int SENSE_WIDTH = 5;
  localparam int CODE_WIDTH = 4;
  localparam int CFG_INDEX_WIDTH = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAP = 2'd2;

  // Register reset values.
  localparam logic [LIMIT_WIDTH-1:0] SETTLE_RESET = 16'd100;
  localparam logic [LIMIT_WIDTH-1:0] HOLD_RESET = 16'd1000;
  localparam logic [LIMIT_WIDTH-1:0] GAP_RESET = 16'd200;

  // Keys per row: row 1 codes follow on from row 0.
  localparam logic [CODE_WIDTH-1:0] KEYS_PER_ROW = 4'd5;

  typedef enum logic [1:0] {
    PH_SETTLE = 2'd0,
    PH_HOLD = 2'd1,
    PH_GAP = 2'd2
  } scan_phase_t;

  typedef struct packed {
    logic [LIMIT_WIDTH-1:0] settle_ticks;
    logic [LIMIT_WIDTH-1:0] hold_ticks;
    logic [LIMIT_WIDTH-1:0] gap_ticks;
  } kps_cfg_t;

  typedef struct packed {
    logic                  row0_drive;
    logic                  row1_drive;
    logic                  key_valid;
    logic [CODE_WIDTH-1:0] key_code;
  } kps_result_t;

  // Saturate a register limit to the counter's range.
  function automatic logic [TIMER_WIDTH-1:0] clamp_limit(input logic [LIMIT_WIDTH-1:0] lim);
    logic [CMP_WIDTH-1:0] lim_ext;
    logic [CMP_WIDTH-1:0] max_ext;
    lim_ext = CMP_WIDTH'(lim);
    max_ext = CMP_WIDTH'(TIMER_MAX);
    if (lim_ext > max_ext) begin
      clamp_limit = TIMER_MAX;
    end else begin
      clamp_limit = lim_ext[TIMER_WIDTH-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/kps_cfg.sv =====
module kps_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kps_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [kps_pkg::LIMIT_WIDTH-1:0]      cfg_data,
  output kps_pkg::kps_cfg_t                    cfg
);
  import kps_pkg::*;

  kps_cfg_t cfg_r;

  // The register file takes a write in every cycle.
  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  // Register writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_ticks <= SETTLE_RESET;
      cfg_r.hold_ticks <= HOLD_RESET;
      cfg_r.gap_ticks <= GAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SETTLE: cfg_r.settle_ticks <= cfg_data;
        REG_HOLD:   cfg_r.hold_ticks <= cfg_data;
        REG_GAP:    cfg_r.gap_ticks <= cfg_data;
        default:    ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/kps_scan.sv =====
module kps_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [kps_pkg::SENSE_WIDTH-1:0]  sense_lines,
  input  kps_pkg::kps_cfg_t                cfg,
  output kps_pkg::kps_result_t             result
);
  import kps_pkg::*;

  scan_phase_t            phase_r, phase_nxt;
  logic                   row_r, row_nxt;
  logic [TIMER_WIDTH-1:0] tick_r, tick_nxt;
  logic [1:0]             drive_r, drive_nxt;

  logic [TIMER_WIDTH-1:0] count;
  logic [TIMER_WIDTH-1:0] settle_lim;
  logic [TIMER_WIDTH-1:0] hold_lim;
  logic [TIMER_WIDTH-1:0] gap_lim;
  logic [CODE_WIDTH-1:0]  col;
  logic                   found;

  // Saturating tick count and limits for this tick.
  assign count = (tick_r == TIMER_MAX) ? TIMER_MAX : tick_r + 1'b1;
  assign hold_lim = clamp_limit(cfg.hold_ticks);
  assign gap_lim = clamp_limit(cfg.gap_ticks);
  always_comb begin
    settle_lim = clamp_limit(cfg.settle_ticks);
    if (settle_lim == '0) begin
      settle_lim = TIMER_WIDTH'(1);
    end
  end

  // Lowest set sense line wins, numbered from one.
  always_comb begin
    col = '0;
    for (int i = SENSE_WIDTH - 1; i >= 0; i--) begin
      if (sense_lines[i]) begin
        col = CODE_WIDTH'(i + 1);
      end
    end
  end
  assign found = (col != '0);

  // Next state. An empty hold or gap falls through to the following phase.
  always_comb begin
    phase_nxt = phase_r;
    row_nxt = row_r;
    tick_nxt = tick_r;
    drive_nxt = drive_r;
    unique case (phase_r)
      PH_SETTLE: begin
        if (count >= settle_lim || count == TIMER_MAX) begin
          row_nxt = ~row_r;
          tick_nxt = '0;
          if (found) begin
            drive_nxt = 2'b00;
          end
          if (found && hold_lim != '0) begin
            phase_nxt = PH_HOLD;
          end else if (gap_lim != '0) begin
            phase_nxt = PH_GAP;
          end else begin
            phase_nxt = PH_SETTLE;
            drive_nxt = row_r ? 2'b01 : 2'b10;
          end
        end else begin
          tick_nxt = count;
        end
      end
      PH_HOLD: begin
        if (count >= hold_lim || count == TIMER_MAX) begin
          tick_nxt = '0;
          if (gap_lim != '0) begin
            phase_nxt = PH_GAP;
          end else begin
            phase_nxt = PH_SETTLE;
            drive_nxt = row_r ? 2'b10 : 2'b01;
          end
        end else begin
          tick_nxt = count;
        end
      end
      PH_GAP: begin
        if (count >= gap_lim || count == TIMER_MAX) begin
          tick_nxt = '0;
          phase_nxt = PH_SETTLE;
          drive_nxt = row_r ? 2'b10 : 2'b01;
        end else begin
          tick_nxt = count;
        end
      end
      default: begin
        // An unused phase code starts the next settle.
        tick_nxt = '0;
        phase_nxt = PH_SETTLE;
        drive_nxt = row_r ? 2'b10 : 2'b01;
      end
    endcase
  end

  // Result of this tick: drive levels after the step and any key found.
  always_comb begin
    result.row0_drive = drive_nxt[0];
    result.row1_drive = drive_nxt[1];
    result.key_valid = 1'b0;
    result.key_code = '0;
    if (phase_r == PH_SETTLE && (count >= settle_lim || count == TIMER_MAX) && found) begin
      result.key_valid = 1'b1;
      result.key_code = row_r ? col + KEYS_PER_ROW : col;
    end
  end

  // Scan state advances on each accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETTLE;
      row_r <= 1'b0;
      tick_r <= '0;
      drive_r <= 2'b01;
    end else if (step) begin
      phase_r <= phase_nxt;
      row_r <= row_nxt;
      tick_r <= tick_nxt;
      drive_r <= drive_nxt;
    end
  end

endmodule

// ===== hw/rtl/kps_out.sv =====
module kps_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kps_pkg::kps_result_t  in_result,
  output logic                  out_valid,
  input  logic                  out_stall,
  output kps_pkg::kps_result_t  out_result
);
  import kps_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  kps_result_t out_data_r;
  kps_result_t skid_data_r;
  logic        accept;
  logic        out_free;

  // New ticks are refused only while the skid stage is occupied.
  assign in_stall = skid_valid_r;
  assign accept = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_result = out_data_r;

  // Occupancy of the output and skid stages.
  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      out_valid_nxt = skid_valid_r || accept;
      skid_valid_nxt = 1'b0;
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload moves with the transfer; the skid stage drains first.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= in_result;
      end
    end else if (accept) begin
      skid_data_r <= in_result;
    end
  end

endmodule

// ===== hw/rtl/two_row_keypad_scanner.sv =====
// Two-row keypad scanner. Each input transfer is one timer tick with the sampled
// sense lines, and each tick yields exactly one result: the row drive levels in
// force after the tick, plus a key report (codes 1 to 5 for row 0, 6 to 10 for
// row 1) on the tick a settle ends with a sense line set. One tick is taken per
// clock while in_stall is low; each result is registered, and a two-entry output
// stage lets ticks keep flowing while a result waits to be taken. Registers
// settle_ticks, hold_ticks and gap_ticks (indexes 0 to 2) should be written
// while no ticks are in flight; they take effect from the next tick.
module two_row_keypad_scanner (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [kps_pkg::SENSE_WIDTH-1:0]      in_sense_lines,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_row0_drive,
  output logic                                 out_row1_drive,
  output logic                                 out_key_valid,
  output logic [kps_pkg::CODE_WIDTH-1:0]       out_key_code,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kps_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [kps_pkg::LIMIT_WIDTH-1:0]      cfg_data
);
  import kps_pkg::*;

  kps_cfg_t    cfg;
  kps_result_t step_result;
  kps_result_t out_result;
  logic        step;

  assign step = in_valid && !in_stall;

  kps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kps_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .sense_lines (in_sense_lines),
    .cfg         (cfg),
    .result      (step_result)
  );

  kps_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_result  (step_result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_row0_drive = out_result.row0_drive;
  assign out_row1_drive = out_result.row1_drive;
  assign out_key_valid = out_result.key_valid;
  assign out_key_code = out_result.key_code;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import kps_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_BLOCKS = 27;
  localparam int TICKS_PER_BLOCK = 40;
  localparam int PRESSURE_BLOCK = 6;
  localparam int IDLE_FREE_FIRST = 14;
  localparam int IDLE_FREE_LAST = 17;
  localparam int IDLE_PERCENT = 37;

  // Index three is not a register; writes to it must be ignored.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_TOP = {LIMIT_WIDTH{1'b1}};

  // One row of the directed table: either a register write or a tick.
  typedef struct packed {
    logic                       is_write;
    logic [CFG_INDEX_WIDTH-1:0] reg_idx;
    logic [LIMIT_WIDTH-1:0]     wdata;
    logic [SENSE_WIDTH-1:0]     lines;
    logic                       typed;
    kps_result_t                want;
  } plan_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [SENSE_WIDTH-1:0]     in_sense_lines = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_row0_drive;
  logic                       out_row1_drive;
  logic                       out_key_valid;
  logic [CODE_WIDTH-1:0]      out_key_code;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [LIMIT_WIDTH-1:0]     cfg_data = '0;

  // Scanner model state and its copy of the registers.
  logic                   row_sel = 1'b0;
  scan_phase_t            phase = PH_SETTLE;
  logic [TIMER_WIDTH-1:0] tick_cnt = '0;
  logic [1:0]             drive = 2'b01;
  logic [LIMIT_WIDTH-1:0] settle_lim = SETTLE_RESET;
  logic [LIMIT_WIDTH-1:0] hold_lim = HOLD_RESET;
  logic [LIMIT_WIDTH-1:0] gap_lim = GAP_RESET;

  kps_result_t pending [$];
  plan_row_t   plan [$];

  int  mismatches = 0;
  int  ticks_sent = 0;
  int  results_seen = 0;
  int  keys_seen = 0;
  int  writes_done = 0;
  int  quiet_cycles = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic hold_off_req = 1'b0;

  two_row_keypad_scanner i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sense_lines (in_sense_lines),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row0_drive (out_row0_drive),
    .out_row1_drive (out_row1_drive),
    .out_key_valid  (out_key_valid),
    .out_key_code   (out_key_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Limits beyond the counter's range saturate to its maximum.
  function automatic logic [TIMER_WIDTH-1:0] sat_limit(input logic [LIMIT_WIDTH-1:0] lim);
    if (longint'(lim) > longint'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return TIMER_WIDTH'(lim);
  endfunction

  function automatic void enter_settle();
    phase = PH_SETTLE;
    tick_cnt = '0;
    drive = row_sel ? 2'b10 : 2'b01;
  endfunction

  // A zero gap falls straight through to the next row's settle.
  function automatic void enter_gap();
    if (sat_limit(gap_lim) == '0) begin
      enter_settle();
    end else begin
      phase = PH_GAP;
      tick_cnt = '0;
    end
  endfunction

  // Advance the scanner by one tick and return the result it reports.
  function automatic kps_result_t scan_tick(input logic [SENSE_WIDTH-1:0] lines);
    kps_result_t            res;
    logic [TIMER_WIDTH-1:0] cnt;
    logic [TIMER_WIDTH-1:0] lim;
    logic                   row;
    int                     col;
    res = '0;
    cnt = (tick_cnt == TIMER_MAX) ? TIMER_MAX : tick_cnt + 1'b1;
    case (phase)
      PH_SETTLE: begin
        lim = sat_limit(settle_lim);
        if (lim == '0) begin
          lim = TIMER_WIDTH'(1);
        end
        if (cnt >= lim || cnt == TIMER_MAX) begin
          // The lowest set sense line wins.
          col = 0;
          for (int i = SENSE_WIDTH - 1; i >= 0; i--) begin
            if (lines[i]) begin
              col = i + 1;
            end
          end
          row = row_sel;
          row_sel = ~row_sel;
          if (col != 0) begin
            res.key_valid = 1'b1;
            res.key_code = CODE_WIDTH'(col) + (row ? KEYS_PER_ROW : 4'd0);
            drive = 2'b00;
            if (sat_limit(hold_lim) == '0) begin
              enter_gap();
            end else begin
              phase = PH_HOLD;
              tick_cnt = '0;
            end
          end else begin
            enter_gap();
          end
        end else begin
          tick_cnt = cnt;
        end
      end
      PH_HOLD: begin
        if (cnt >= sat_limit(hold_lim) || cnt == TIMER_MAX) begin
          enter_gap();
        end else begin
          tick_cnt = cnt;
        end
      end
      PH_GAP: begin
        if (cnt >= sat_limit(gap_lim) || cnt == TIMER_MAX) begin
          enter_settle();
        end else begin
          tick_cnt = cnt;
        end
      end
      default: begin
        enter_settle();
      end
    endcase
    res.row0_drive = drive[0];
    res.row1_drive = drive[1];
    return res;
  endfunction

  function automatic plan_row_t wr(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                   input logic [LIMIT_WIDTH-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.wdata = data;
    return r;
  endfunction

  function automatic plan_row_t tk(input logic [SENSE_WIDTH-1:0] lines);
    plan_row_t r;
    r = '0;
    r.lines = lines;
    return r;
  endfunction

  function automatic plan_row_t tk_want(input logic [SENSE_WIDTH-1:0] lines, input logic r0,
                                        input logic r1, input logic kv,
                                        input logic [CODE_WIDTH-1:0] code);
    plan_row_t r;
    r = tk(lines);
    r.typed = 1'b1;
    r.want = '{row0_drive: r0, row1_drive: r1, key_valid: kv, key_code: code};
    return r;
  endfunction

  // Stop offering ticks and wait until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write, only ever issued with the scanner idle.
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [LIMIT_WIDTH-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SETTLE: settle_lim = data;
      REG_HOLD:   hold_lim = data;
      REG_GAP:    gap_lim = data;
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one tick; on its transfer the model is stepped and its result queued.
  task automatic send_tick(input logic [SENSE_WIDTH-1:0] lines, input logic typed,
                           input kps_result_t want);
    kps_result_t exp_res;
    if (tx_idle_on) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_sense_lines <= lines;
    do @(posedge clk); while (in_stall);
    exp_res = scan_tick(lines);
    pending.push_back(typed ? want : exp_res);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  // Receiver stall: random idling, or one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    kps_result_t want_res;
    kps_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{row0_drive: out_row0_drive, row1_drive: out_row1_drive,
              key_valid: out_key_valid, key_code: out_key_code};
      if (pending.size() == 0) begin
        note_failure($sformatf("tb: unexpected result row0=%0b row1=%0b key=%0b code=%0d",
                               got.row0_drive, got.row1_drive, got.key_valid, got.key_code));
      end else begin
        want_res = pending.pop_front();
        results_seen++;
        if (want_res.key_valid) begin
          keys_seen++;
        end
        if (got.row0_drive !== want_res.row0_drive || got.row1_drive !== want_res.row1_drive ||
            got.key_valid !== want_res.key_valid || got.key_code !== want_res.key_code) begin
          note_failure($sformatf(
            "tb: result %0d expected row0=%0b row1=%0b key=%0b code=%0d, got %0b %0b %0b %0d",
            results_seen, want_res.row0_drive, want_res.row1_drive, want_res.key_valid,
            want_res.key_code, got.row0_drive, got.row1_drive, got.key_valid, got.key_code));
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [SENSE_WIDTH-1:0] lines;
    int                     pick;

    // Directed ticks: reset state, shortest timing, both rows, extremes and
    // limits changed while a phase is under way.
    plan = '{
      tk_want(5'b00000, 1'b1, 1'b0, 1'b0, 4'd0),
      wr(REG_SETTLE, '0), wr(REG_HOLD, '0), wr(REG_GAP, '0),
      tk_want(5'b00001, 1'b0, 1'b1, 1'b1, 4'd1),
      tk_want(5'b10000, 1'b1, 1'b0, 1'b1, 4'd10),
      tk_want(5'b11111, 1'b0, 1'b1, 1'b1, 4'd1),
      tk_want(5'b00000, 1'b1, 1'b0, 1'b0, 4'd0),
      tk_want(5'b00000, 1'b0, 1'b1, 1'b0, 4'd0),
      tk(5'b01100),
      wr(REG_SETTLE, 16'd2), wr(REG_HOLD, 16'd1), wr(REG_GAP, 16'd1),
      tk(5'b00010), tk(5'b00010), tk(5'b00100), tk(5'b01000), tk(5'b00000), tk(5'b00001),
      wr(REG_HOLD, LIMIT_TOP), wr(REG_GAP, LIMIT_TOP), wr(REG_UNUSED, LIMIT_TOP),
      tk(5'b01010), tk(5'b00100), tk(5'b00001), tk(5'b10000),
      wr(REG_HOLD, '0),
      tk(5'b00000), tk(5'b00000),
      wr(REG_GAP, 16'd1),
      tk(5'b00000),
      wr(REG_SETTLE, LIMIT_TOP),
      tk(5'b00000), tk(5'b11111), tk(5'b00000),
      wr(REG_SETTLE, 16'd1),
      tk(5'b11111), tk(5'b10101)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        write_reg(plan[i].reg_idx, plan[i].wdata);
      end else begin
        send_tick(plan[i].lines, plan[i].typed, plan[i].want);
      end
    end

    // Random blocks: mostly short timings so keys turn up often, with the
    // extreme limits now and then and a stretch with no idling at all.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      wait_drained();
      case (blk)
        2: write_reg(REG_SETTLE, LIMIT_TOP);
        4: begin
          write_reg(REG_SETTLE, 16'd1);
          write_reg(REG_HOLD, LIMIT_TOP);
        end
        8: begin
          write_reg(REG_HOLD, '0);
          write_reg(REG_GAP, LIMIT_TOP);
        end
        9: write_reg(REG_UNUSED, LIMIT_WIDTH'($urandom));
        12: begin
          write_reg(REG_SETTLE, '0);
          write_reg(REG_HOLD, '0);
          write_reg(REG_GAP, '0);
        end
        default: begin
          if ($urandom_range(9) < 7) write_reg(REG_SETTLE, LIMIT_WIDTH'($urandom_range(5)));
          if ($urandom_range(9) < 7) write_reg(REG_HOLD, LIMIT_WIDTH'($urandom_range(6)));
          if ($urandom_range(9) < 7) write_reg(REG_GAP, LIMIT_WIDTH'($urandom_range(4)));
        end
      endcase
      tx_idle_on = !(blk >= IDLE_FREE_FIRST && blk <= IDLE_FREE_LAST);
      // Change the receiver's mode away from the edge it acts on.
      @(posedge clk);
      rx_idle_on = tx_idle_on;
      if (blk == PRESSURE_BLOCK) begin
        hold_off_req = 1'b1;
      end
      @(negedge clk);
      repeat (TICKS_PER_BLOCK) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          lines = '0;
        end else if (pick < 65) begin
          lines = SENSE_WIDTH'(1 << $urandom_range(SENSE_WIDTH - 1));
        end else begin
          lines = SENSE_WIDTH'($urandom);
        end
        send_tick(lines, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d ticks over many timing settings, %0d results checked, %0d key reports",
             ticks_sent, results_seen, keys_seen);
    $display("tb: %0d register writes, %0d mismatches", writes_done, mismatches);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== two_row_keypad_scanner.f =====
hw/rtl/kps_pkg.sv
hw/rtl/kps_cfg.sv
hw/rtl/kps_scan.sv
hw/rtl/kps_out.sv
hw/rtl/two_row_keypad_scanner.sv
tb/tb_top.sv
